[rtl/ctt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_pkg
// types, codes and character constants for the configuration text tokenizer
// ----------------------------------------------------------------------------
package ctt_pkg;

  // default limits
  localparam int unsigned MaxWordLenDefault = 4096;
  localparam int unsigned MaxNestingDefault = 16;

  // fixed field widths
  localparam int unsigned NestW = 5;
  localparam int unsigned ArgW  = 8;
  localparam int unsigned LineW = 24;

  localparam logic [ArgW-1:0]  ArgMax  = '1;
  localparam logic [LineW-1:0] LineMax = '1;

  // characters
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChSemi   = 8'h3b;
  localparam logic [7:0] ChLBrace = 8'h7b;
  localparam logic [7:0] ChRBrace = 8'h7d;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChDQuote = 8'h22;
  localparam logic [7:0] ChSQuote = 8'h27;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_DIR_END     = 3'd1,
    EV_BLOCK_START = 3'd2,
    EV_BLOCK_END   = 3'd3,
    EV_CLEAN_END   = 3'd4,
    EV_ERROR       = 3'd5
  } event_e;

  typedef enum logic [3:0] {
    ERR_STRAY_AFTER_QUOTE = 4'd0,
    ERR_EMPTY_DIRECTIVE   = 4'd1,
    ERR_BLOCK_NO_NAME     = 4'd2,
    ERR_CLOSE_AFTER_ARGS  = 4'd3,
    ERR_EOF_IN_DIRECTIVE  = 4'd4,
    ERR_CLOSE_AT_TOP      = 4'd5,
    ERR_EOF_IN_BLOCK      = 4'd6,
    ERR_WORD_TOO_LONG     = 4'd7,
    ERR_NESTING_TOO_DEEP  = 4'd8
  } err_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } tok_in_t;

  typedef struct packed {
    logic             word_byte;
    logic             word_start;
    logic             word_end;
    event_e           event_res;
    err_e             error_code;
    logic [LineW-1:0] line_number;
    logic [NestW-1:0] nesting_depth;
    logic [ArgW-1:0]  argument_count;
  } tok_out_t;

endpackage

[rtl/config_text_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_text_tokenizer
// byte-at-a-time tokenizer for block-structured configuration text
// ----------------------------------------------------------------------------
// One transaction carries one text byte or the end-of-input marker, and each
// one produces exactly one result transaction. The block sustains one
// transaction per cycle: the whole tokenizer state (quote and comment flags,
// word length, argument, depth and line counters) is updated combinationally
// between the input register and the result register, so an item passes
// the input register and then the result register, and throughput is one
// item per clock while the output side takes results. The input register
// can hold one more item while a result waits under stall. Any error halts
// the tokenizer: every later item reports the held error code until reset.
module config_text_tokenizer #(
  parameter int unsigned MAX_WORD_LEN = ctt_pkg::MaxWordLenDefault,
  parameter int unsigned MAX_NESTING  = ctt_pkg::MaxNestingDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ctt_pkg::tok_in_t  in_data_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ctt_pkg::tok_out_t out_data_o
);
  import ctt_pkg::*;

  localparam int unsigned WlenW  = $clog2(MAX_WORD_LEN + 1);
  localparam int unsigned DepthW = $clog2(MAX_NESTING + 1);

  localparam logic [WlenW-1:0]  WlenLimit  = WlenW'(MAX_WORD_LEN);
  localparam logic [DepthW-1:0] DepthLimit = DepthW'(MAX_NESTING);

  // pipeline registers
  logic     in_valid_q;
  tok_in_t  in_q;
  logic     out_valid_q;
  tok_out_t out_q;
  tok_out_t res;

  // tokenizer state
  logic              comment_q, comment_d;
  logic              dquote_q, dquote_d;
  logic              squote_q, squote_d;
  logic              need_sep_q, need_sep_d;
  logic              after_space_q, after_space_d;
  logic [ArgW-1:0]   arg_q, arg_d;
  logic [WlenW-1:0]  wlen_q, wlen_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [LineW-1:0]  line_q, line_d;
  logic              halted_q, halted_d;
  err_e              err_q, err_d;

  logic advance;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
  endfunction

  // an item moves to the result register when that register is free or leaving
  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;

  always_comb begin
    logic [7:0] c;
    logic       clear;
    logic       restart;
    logic       in_comment_now;
    logic       closes;
    logic       text;
    logic       open_req;
    logic       wb, ws, we;
    event_e     ev;

    c              = in_q.text_byte;
    clear          = 1'b0;
    restart        = 1'b0;
    closes         = 1'b0;
    text           = 1'b0;
    open_req       = 1'b0;
    wb             = 1'b0;
    ws             = 1'b0;
    we             = 1'b0;
    ev             = EV_NONE;
    in_comment_now = comment_q && (c != ChLf);

    comment_d     = comment_q;
    dquote_d      = dquote_q;
    squote_d      = squote_q;
    need_sep_d    = need_sep_q;
    after_space_d = after_space_q;
    arg_d         = arg_q;
    wlen_d        = wlen_q;
    depth_d       = depth_q;
    line_d        = line_q;
    halted_d      = halted_q;
    err_d         = err_q;

    if (halted_q) begin
      ev = EV_ERROR;
    end else if (in_q.end_of_input) begin
      if ((arg_q != '0) || !after_space_q) begin
        ev       = EV_ERROR;
        halted_d = 1'b1;
        err_d    = ERR_EOF_IN_DIRECTIVE;
      end else if (depth_q != '0) begin
        ev       = EV_ERROR;
        halted_d = 1'b1;
        err_d    = ERR_EOF_IN_BLOCK;
      end else begin
        ev      = EV_CLEAN_END;
        restart = 1'b1;
      end
    end else begin
      // every line feed counts a line and ends a comment
      if (c == ChLf) begin
        if (line_q != LineMax) begin
          line_d = line_q + 1'b1;
        end
        comment_d = 1'b0;
      end
      if (in_comment_now) begin
        // comment text is dropped
      end else if (need_sep_q) begin
        if (is_blank(c)) begin
          after_space_d = 1'b1;
          need_sep_d    = 1'b0;
        end else if (c == ChSemi) begin
          ev = EV_DIR_END;
        end else if (c == ChLBrace) begin
          open_req = 1'b1;
        end else begin
          ev       = EV_ERROR;
          halted_d = 1'b1;
          err_d    = ERR_STRAY_AFTER_QUOTE;
        end
      end else if (after_space_q) begin
        if (is_blank(c)) begin
          // skip
        end else if (c == ChSemi) begin
          if (arg_q == '0) begin
            ev       = EV_ERROR;
            halted_d = 1'b1;
            err_d    = ERR_EMPTY_DIRECTIVE;
          end else begin
            ev = EV_DIR_END;
          end
        end else if (c == ChLBrace) begin
          if (arg_q == '0) begin
            ev       = EV_ERROR;
            halted_d = 1'b1;
            err_d    = ERR_BLOCK_NO_NAME;
          end else begin
            open_req = 1'b1;
          end
        end else if (c == ChRBrace) begin
          if (arg_q != '0) begin
            ev       = EV_ERROR;
            halted_d = 1'b1;
            err_d    = ERR_CLOSE_AFTER_ARGS;
          end else if (depth_q == '0) begin
            ev       = EV_ERROR;
            halted_d = 1'b1;
            err_d    = ERR_CLOSE_AT_TOP;
          end else begin
            depth_d = depth_q - 1'b1;
            ev      = EV_BLOCK_END;
          end
        end else if (c == ChHash) begin
          comment_d = 1'b1;
        end else begin
          ws            = 1'b1;
          after_space_d = 1'b0;
          if (c == ChDQuote) begin
            dquote_d = 1'b1;
            wlen_d   = '0;
          end else if (c == ChSQuote) begin
            squote_d = 1'b1;
            wlen_d   = '0;
          end else begin
            wb     = 1'b1;
            wlen_d = WlenW'(1);
          end
        end
      end else begin
        // inside a word
        if (dquote_q) begin
          if (c == ChDQuote) begin
            dquote_d   = 1'b0;
            need_sep_d = 1'b1;
            closes     = 1'b1;
          end else begin
            text = 1'b1;
          end
        end else if (squote_q) begin
          if (c == ChSQuote) begin
            squote_d   = 1'b0;
            need_sep_d = 1'b1;
            closes     = 1'b1;
          end else begin
            text = 1'b1;
          end
        end else if (is_blank(c) || (c == ChSemi) || (c == ChLBrace)) begin
          after_space_d = 1'b1;
          closes        = 1'b1;
        end else begin
          text = 1'b1;
        end

        if (text) begin
          if (wlen_q >= WlenLimit) begin
            ev       = EV_ERROR;
            halted_d = 1'b1;
            err_d    = ERR_WORD_TOO_LONG;
          end else begin
            wlen_d = wlen_q + 1'b1;
            wb     = 1'b1;
          end
        end else if (closes) begin
          we     = 1'b1;
          wlen_d = '0;
          if (arg_q != ArgMax) begin
            arg_d = arg_q + 1'b1;
          end
          if (c == ChSemi) begin
            ev = EV_DIR_END;
          end else if (c == ChLBrace) begin
            open_req = 1'b1;
          end
        end
      end

      // block open, shared by the bare and quoted paths
      if (open_req) begin
        if (depth_q >= DepthLimit) begin
          ev       = EV_ERROR;
          halted_d = 1'b1;
          err_d    = ERR_NESTING_TOO_DEEP;
        end else begin
          depth_d = depth_q + 1'b1;
          ev      = EV_BLOCK_START;
        end
      end
    end

    // error items carry no word flags
    if (ev == EV_ERROR) begin
      wb = 1'b0;
      ws = 1'b0;
      we = 1'b0;
    end

    res.word_byte      = wb;
    res.word_start     = ws;
    res.word_end       = we;
    res.event_res      = ev;
    res.error_code     = (ev == EV_ERROR) ? err_d : ERR_STRAY_AFTER_QUOTE;
    res.line_number    = line_d;
    res.nesting_depth  = NestW'(depth_d);
    res.argument_count = arg_d;

    // directive end, block start and block end begin a fresh directive
    clear = (ev == EV_DIR_END) || (ev == EV_BLOCK_START) || (ev == EV_BLOCK_END);
    if (clear || restart) begin
      comment_d     = 1'b0;
      dquote_d      = 1'b0;
      squote_d      = 1'b0;
      need_sep_d    = 1'b0;
      after_space_d = 1'b1;
      arg_d         = '0;
      wlen_d        = '0;
    end
    // a clean end lets a new text start from line one
    if (restart) begin
      line_d = LineW'(1);
    end
  end

  // tokenizer state, updated once per item moving to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_q     <= 1'b0;
      dquote_q      <= 1'b0;
      squote_q      <= 1'b0;
      need_sep_q    <= 1'b0;
      after_space_q <= 1'b1;
      arg_q         <= '0;
      wlen_q        <= '0;
      depth_q       <= '0;
      line_q        <= LineW'(1);
      halted_q      <= 1'b0;
      err_q         <= ERR_STRAY_AFTER_QUOTE;
    end else if (advance) begin
      comment_q     <= comment_d;
      dquote_q      <= dquote_d;
      squote_q      <= squote_d;
      need_sep_q    <= need_sep_d;
      after_space_q <= after_space_d;
      arg_q         <= arg_d;
      wlen_q        <= wlen_d;
      depth_q       <= depth_d;
      line_q        <= line_d;
      halted_q      <= halted_d;
      err_q         <= err_d;
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // once halted, the tokenizer stays halted
  assert property (@(posedge clk_i) disable iff (!rst_ni) halted_q |=> halted_q)
    else $error("halted flag cleared without reset");

  // a halted tokenizer answers every item with an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && halted_q) |=> (out_data_o.event_res == EV_ERROR))
    else $error("item after an error did not report the error");

  // error results carry no word flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.event_res == EV_ERROR)) |->
      !(out_data_o.word_byte || out_data_o.word_start || out_data_o.word_end))
    else $error("word flag set on an error result");

  // comment and quote modes exclude each other
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(comment_q && (dquote_q || squote_q)) && !(dquote_q && squote_q))
    else $error("conflicting comment and quote modes");

  // block depth never passes the nesting limit
  assert property (@(posedge clk_i) disable iff (!rst_ni) depth_q <= DepthLimit)
    else $error("nesting depth beyond the limit");

endmodule
